### rtl/sia_pkg.sv
`default_nettype none
package sia_pkg;

    localparam int NUM_SLOTS     = 4;
    localparam int NUM_CAP_REGS  = 4;
    localparam int MAX_INDICES   = 256;
    localparam int SLOT_W        = 2;
    localparam int IDX_W         = 8;
    localparam int CAP_W         = 9;
    localparam int OP_W          = 2;
    localparam int STAT_W        = 2;
    localparam int CFG_ADDR_W    = 2;
    localparam int S_TDATA_W     = 16;
    localparam int M_TDATA_W     = 16;

    // bound marks live in rows of ROW_W bits, one valid flop per row
    localparam int ROW_W         = 32;
    localparam int ROW_BITS      = 5;
    localparam int ROWS_PER_SLOT = MAX_INDICES / ROW_W;
    localparam int ROW_SEL_W     = IDX_W - ROW_BITS;
    localparam int ROW_ADDR_W    = SLOT_W + ROW_SEL_W;
    localparam int NUM_ROWS      = NUM_SLOTS * ROWS_PER_SLOT;

    localparam int STK_ADDR_W    = SLOT_W + IDX_W;
    localparam int STK_DEPTH     = NUM_SLOTS * MAX_INDICES;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_RESET = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_BOUND = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BAD_SLOT  = 2'd3;

    typedef struct packed {
        logic accept;
        logic pop;
        logic finish;
        logic mark;
    } sia_cmd_t;

    typedef struct packed {
        logic alloc_go;
        logic out_free;
    } sia_sts_t;

    function automatic logic [CAP_W-1:0] cap_eff(input logic [CAP_W-1:0] c);
        cap_eff = (c > CAP_W'(MAX_INDICES)) ? CAP_W'(MAX_INDICES) : c;
    endfunction

endpackage
`default_nettype wire

### rtl/sia_ctrl.sv
`default_nettype none
module sia_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  sia_pkg::sia_sts_t sts,
    output sia_pkg::sia_cmd_t cmd
);
    import sia_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_MARK = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (sts.alloc_go) begin
                    cmd.pop    = 1'b1;
                    state_next = S_MARK;
                end else if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_MARK: begin
                if (sts.out_free) begin
                    cmd.mark   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/sia_datapath.sv
`default_nettype none
module sia_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [sia_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic [sia_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_wr_en,
    input  logic [sia_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [sia_pkg::CAP_W-1:0]       cfg_wr_data,
    input  sia_pkg::sia_cmd_t               cmd,
    output sia_pkg::sia_sts_t               sts
);
    import sia_pkg::*;

    logic [OP_W-1:0]    in_op;
    logic [SLOT_W-1:0]  in_slot;
    logic [IDX_W-1:0]   in_idx;

    logic [OP_W-1:0]    op_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   top_reg;

    logic [CAP_W-1:0]   cap_reg   [NUM_CAP_REGS];
    logic [CAP_W-1:0]   depth_reg [NUM_SLOTS];
    logic [CAP_W-1:0]   prist_reg [NUM_SLOTS];
    logic [NUM_ROWS-1:0] row_valid_reg;

    logic [IDX_W-1:0]   stack_mem [STK_DEPTH];
    logic [IDX_W-1:0]   stack_rdata_reg;
    logic [ROW_W-1:0]   row_mem   [NUM_ROWS];
    logic [ROW_W-1:0]   row_rdata_reg;

    logic               m_tvalid_reg;
    logic [STAT_W-1:0]  status_reg;
    logic [IDX_W-1:0]   gidx_reg;
    logic [SLOT_W-1:0]  gslot_reg;

    logic               slot_ok;
    logic [CAP_W-1:0]   cur_depth, cur_prist, cur_eff, pop_pos, prist_val;
    logic [IDX_W-1:0]   pop_top;
    logic [ROW_ADDR_W-1:0] free_row_addr, mark_row_addr, row_raddr, row_waddr;
    logic [ROW_W-1:0]   free_base, mark_base, free_bit, mark_bit, row_wdata;
    logic               free_bound, row_we, stk_we, push_ok, exec_free_ok, exec_reset;
    logic [STK_ADDR_W-1:0] stk_raddr, stk_waddr;
    logic [CAP_W-1:0]   in_depth_m1;
    logic [STAT_W-1:0]  fin_status;

    assign in_op   = s_tdata[OP_W-1:0];
    assign in_slot = s_tdata[OP_W +: SLOT_W];
    assign in_idx  = s_tdata[OP_W+SLOT_W +: IDX_W];

    assign slot_ok   = ({1'b0, slot_reg} < (SLOT_W+1)'(NUM_SLOTS));
    assign cur_depth = depth_reg[slot_reg];
    assign cur_prist = prist_reg[slot_reg];
    assign cur_eff   = cap_eff(cap_reg[slot_reg]);

    // entries below the pristine mark still hold the refill pattern
    assign pop_pos   = cur_depth - CAP_W'(1);
    assign prist_val = cur_eff - CAP_W'(1) - pop_pos;
    assign pop_top   = (pop_pos < cur_prist) ? prist_val[IDX_W-1:0] : stack_rdata_reg;

    assign free_row_addr = {slot_reg, idx_reg[IDX_W-1:ROW_BITS]};
    assign mark_row_addr = {slot_reg, top_reg[IDX_W-1:ROW_BITS]};
    assign free_base  = row_valid_reg[free_row_addr] ? row_rdata_reg : '0;
    assign mark_base  = row_valid_reg[mark_row_addr] ? row_rdata_reg : '0;
    assign free_bit   = ROW_W'(1) << idx_reg[ROW_BITS-1:0];
    assign mark_bit   = ROW_W'(1) << top_reg[ROW_BITS-1:0];
    assign free_bound = |(free_base & free_bit);

    assign push_ok      = (cur_depth < CAP_W'(MAX_INDICES));
    assign exec_free_ok = cmd.finish && slot_ok && (op_reg == OP_FREE) && free_bound;
    assign exec_reset   = cmd.finish && slot_ok && (op_reg == OP_RESET);

    assign row_raddr = cmd.accept ? {in_slot, in_idx[IDX_W-1:ROW_BITS]}
                                  : {slot_reg, pop_top[IDX_W-1:ROW_BITS]};
    assign row_we    = exec_free_ok || cmd.mark;
    assign row_waddr = cmd.mark ? mark_row_addr : free_row_addr;
    assign row_wdata = cmd.mark ? (mark_base | mark_bit) : (free_base & ~free_bit);

    assign in_depth_m1 = depth_reg[in_slot] - CAP_W'(1);
    assign stk_raddr   = {in_slot, in_depth_m1[IDX_W-1:0]};
    assign stk_we      = exec_free_ok && push_ok;
    assign stk_waddr   = {slot_reg, cur_depth[IDX_W-1:0]};

    assign sts.alloc_go = slot_ok && (op_reg == OP_ALLOC) && (cur_depth != '0);
    assign sts.out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        fin_status = STAT_OK;
        if (!slot_ok) begin
            fin_status = STAT_BAD_SLOT;
        end else begin
            case (op_reg)
                OP_ALLOC: fin_status = STAT_EMPTY;
                OP_FREE:  fin_status = free_bound ? STAT_OK : STAT_NOT_BOUND;
                default:  fin_status = STAT_OK;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stack_mem[stk_waddr] <= idx_reg;
        end
        if (cmd.accept) begin
            stack_rdata_reg <= stack_mem[stk_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (row_we) begin
            row_mem[row_waddr] <= row_wdata;
        end
        if (cmd.accept || cmd.pop) begin
            row_rdata_reg <= row_mem[row_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg   <= in_op;
            slot_reg <= in_slot;
            idx_reg  <= in_idx;
        end
        if (cmd.pop) begin
            top_reg <= pop_top;
        end
        if (cmd.finish || cmd.mark) begin
            status_reg <= cmd.mark ? STAT_OK : fin_status;
            gidx_reg   <= cmd.mark ? top_reg : '0;
            gslot_reg  <= slot_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CAP_REGS; i++) begin
                cap_reg[i] <= '0;
            end
            for (int s = 0; s < NUM_SLOTS; s++) begin
                depth_reg[s] <= '0;
                prist_reg[s] <= '0;
            end
            row_valid_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            for (int i = 0; i < NUM_CAP_REGS; i++) begin
                if (cfg_wr_en && (cfg_addr == CFG_ADDR_W'(i))) begin
                    cap_reg[i] <= cfg_wr_data;
                end
            end
            if (cmd.pop) begin
                depth_reg[slot_reg] <= pop_pos;
            end
            if (stk_we) begin
                depth_reg[slot_reg] <= cur_depth + CAP_W'(1);
                prist_reg[slot_reg] <= (cur_depth < cur_prist) ? cur_depth : cur_prist;
            end
            if (cmd.mark) begin
                row_valid_reg[mark_row_addr] <= 1'b1;
            end
            // refill: reload depth and pristine mark, drop the slot's bound rows
            for (int s = 0; s < NUM_SLOTS; s++) begin
                if (cfg_wr_en && (cfg_addr == CFG_ADDR_W'(s))) begin
                    depth_reg[s] <= cap_eff(cfg_wr_data);
                    prist_reg[s] <= cap_eff(cfg_wr_data);
                end else if (exec_reset && (slot_reg == SLOT_W'(s))) begin
                    depth_reg[s] <= cap_eff(cap_reg[s]);
                    prist_reg[s] <= cap_eff(cap_reg[s]);
                end
                for (int r = 0; r < ROWS_PER_SLOT; r++) begin
                    if ((cfg_wr_en && (cfg_addr == CFG_ADDR_W'(s))) ||
                        (exec_reset && (slot_reg == SLOT_W'(s)))) begin
                        row_valid_reg[s*ROWS_PER_SLOT + r] <= 1'b0;
                    end
                end
            end
            if (cmd.finish || cmd.mark) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({gslot_reg, gidx_reg, status_reg});

endmodule
`default_nettype wire

### rtl/slotted_index_allocator.sv
// channel   dir  handshake            payload
// s_        in   s_tvalid/s_tready    s_tdata: opcode[1:0] slot[3:2] index[11:4]
// m_        out  m_tvalid/m_tready    m_tdata: status[1:0] granted_index[9:2]
//                                              granted_slot[11:10]
// cfg_      in   cfg_wr_en            cfg_addr register, cfg_wr_data capacity
//
// free, slot reset and an allocate on an empty pool finish in S_EXEC; a granted
// allocate pops in S_EXEC and marks in S_MARK: the free-stack read and the
// bound-mark row read-modify-write are one registered memory port each.
// a slot refill is immediate: a per-slot pristine mark stands in for the
// refill pattern and per-row valid bits clear the bound marks.
// reset is synchronous, active low, and leaves every pool empty.
// the next request is taken while a result still waits in the output register;
// a request finishes only once that register is free.
`default_nettype none
module slotted_index_allocator (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sia_pkg::S_TDATA_W-1:0]   s_tdata,  // opcode, slot, index
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sia_pkg::M_TDATA_W-1:0]   m_tdata,  // status, granted_index, granted_slot
    input  logic                            cfg_wr_en,
    input  logic [sia_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [sia_pkg::CAP_W-1:0]       cfg_wr_data
);
    import sia_pkg::*;

    sia_cmd_t cmd;
    sia_sts_t sts;

    sia_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sia_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .m_tdata     (m_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts)
    );

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a request in work");
`endif

endmodule
`default_nettype wire
